@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define HRV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("hrv assertion failed");

// Checked at every clock edge, reset included.
`define HRV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hrv assertion failed");

`endif

@@ rtl/hrv_pkg.sv @@
// Types, constants and the FNV-1a fold step for the hashed record validator.
// Depends on nothing; imported by every module of the block.
package hrv_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    localparam logic [31:0] RECORD_MAGIC = 32'h4452454D;
    localparam logic [4:0]  MIN_LEN      = 5'd28;
    localparam logic [4:0]  WINDOW_LEN   = 5'd8;
    localparam logic [4:0]  MAGIC_END    = 5'd4;
    localparam logic [4:0]  COUNT_END    = 5'd12;
    localparam logic [4:0]  CYCLE_END    = 5'd20;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_HASH  = 2'd2,
        ST_MAGIC = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [63:0] count;
        logic [63:0] cycle;
    } t_result;

    // One FNV-1a step: xor the byte in, then multiply by 2^40 + 0x1b3.
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ rtl/hashed_record_validator.sv @@
// Top level of the hashed record validator: input register, record core and
// result register. Depends on hrv_pkg, hrv_record_core and hrv_result_reg.
//
//   channel   handshake          payload                                   beat
//   input     i_valid/o_ready    i_byte_value, i_last_byte                 one byte
//   output    o_valid/i_ready    o_status, o_stored_count, o_per_cycle_value one result
//
// A byte is taken in every cycle; only a pending last byte waits on a stalled output, and
// other bytes move on. A last byte goes through the input register and, once the output
// register is free, its result is loaded into the result register, which raises o_valid.
// The hash fold of one byte is a single shift-and-add step, so bytes stream at full rate.
// Reset clears the record state to the FNV offset basis and zeros.
module hashed_record_validator
    import hrv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_stored_count,
    output logic [63:0] o_per_cycle_value
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_advance;
    logic       w_out_free;
    t_result    w_core_result;
    t_result    w_out_result;

    assign w_advance = r_in_valid && (!r_in_last || w_out_free);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    hrv_record_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_byte_value (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_result     (w_core_result)
    );

    hrv_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && r_in_last),
        .i_result (w_core_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_free   (w_out_free),
        .o_result (w_out_result)
    );

    assign o_status          = w_out_result.status;
    assign o_stored_count    = w_out_result.count;
    assign o_per_cycle_value = w_out_result.cycle;

endmodule

@@ rtl/hrv_record_core.sv @@
// Record state: header capture, eight-byte trailer window, running hash and
// the final check. Depends on hrv_pkg.
module hrv_record_core
    import hrv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output t_result     o_result
);

    logic [63:0] r_hash, n_hash;
    logic [63:0] r_tail, n_tail;
    logic [4:0]  r_pos, n_pos;
    logic [31:0] r_magic, n_magic;
    logic [63:0] r_count, n_count;
    logic [63:0] r_cycle, n_cycle;
    logic [4:0]  w_cnt_off;
    logic [4:0]  w_cyc_off;

    assign w_cnt_off = r_pos - MAGIC_END;
    assign w_cyc_off = r_pos - COUNT_END;

    always_comb begin
        n_magic = r_magic;
        n_count = r_count;
        n_cycle = r_cycle;
        if (r_pos < MAGIC_END) begin
            n_magic[{r_pos[1:0], 3'b000} +: 8] = i_byte_value;
        end else if (r_pos < COUNT_END) begin
            n_count[{w_cnt_off[2:0], 3'b000} +: 8] = i_byte_value;
        end else if (r_pos < CYCLE_END) begin
            n_cycle[{w_cyc_off[2:0], 3'b000} +: 8] = i_byte_value;
        end
        n_hash = (r_pos >= WINDOW_LEN) ? fnv_fold(r_hash, r_tail[7:0]) : r_hash;
        n_tail = {i_byte_value, r_tail[63:8]};
        n_pos  = (r_pos < MIN_LEN) ? r_pos + 5'd1 : r_pos;
    end

    always_comb begin
        o_result.count = '0;
        o_result.cycle = '0;
        if (n_pos < MIN_LEN) begin
            o_result.status = ST_SHORT;
        end else if (n_hash != n_tail) begin
            o_result.status = ST_HASH;
        end else if (n_magic != RECORD_MAGIC) begin
            o_result.status = ST_MAGIC;
        end else begin
            o_result.status = ST_OK;
            o_result.count  = n_count;
            o_result.cycle  = n_cycle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last_byte)) begin
            r_hash  <= FNV_BASIS;
            r_tail  <= '0;
            r_pos   <= '0;
            r_magic <= '0;
            r_count <= '0;
            r_cycle <= '0;
        end else if (i_advance) begin
            r_hash  <= n_hash;
            r_tail  <= n_tail;
            r_pos   <= n_pos;
            r_magic <= n_magic;
            r_count <= n_count;
            r_cycle <= n_cycle;
        end
    end

endmodule

@@ rtl/hrv_result_reg.sv @@
// Output register for result beats with valid/ready handshake.
// Depends on hrv_pkg.
module hrv_result_reg
    import hrv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ rtl/hrv_checker.sv @@
// Port-level checks for the hashed record validator, bound to the top level.
// Depends on hrv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrv_checker
    import hrv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_byte_value,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [63:0] o_stored_count,
    input logic [63:0] o_per_cycle_value
);

    logic [8:0]   w_in_beat;
    logic [129:0] w_out_beat;
    logic [127:0] w_out_words;

    assign w_in_beat   = {i_byte_value, i_last_byte};
    assign w_out_beat  = {o_status, o_stored_count, o_per_cycle_value};
    assign w_out_words = {o_stored_count, o_per_cycle_value};

    `HRV_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready |=> i_valid && $stable(w_in_beat))

    `HRV_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(w_out_beat))

    `HRV_ASSERT(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK) |-> w_out_words == '0)

    `HRV_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_ready |-> o_valid && !i_ready)

    `HRV_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind hashed_record_validator hrv_checker u_hrv_checker (.*);
